// File: hdl/aptrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptrc_pkg
// Shared types and constants of the box table with overlap count.
// ----------------------------------------------------------------------------
package aptrc_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;

    localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        [31:0] key;
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/aptrc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module aptrc_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/aptrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptrc_ctrl
// Sequencer: accepts an item, runs the table scan (skipped for clear), commits the result.
// ----------------------------------------------------------------------------
module aptrc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire aptrc_pkg::t_sts i_sts,
    output aptrc_pkg::t_cmd      o_cmd
);

    import aptrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall   = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = i_sts.is_clear ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/aptrc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aptrc_dp
// Datapath: entry RAM, valid bits, scan counter, compare, result register.
// ----------------------------------------------------------------------------
module aptrc_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire aptrc_pkg::t_cmd    i_cmd,
    output aptrc_pkg::t_sts         o_sts,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [31:0] i_object_id,
    input  wire logic signed [31:0] i_min_x,
    input  wire logic signed [31:0] i_min_y,
    input  wire logic signed [31:0] i_min_z,
    input  wire logic signed [31:0] i_max_x,
    input  wire logic signed [31:0] i_max_y,
    input  wire logic signed [31:0] i_max_z,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [aptrc_pkg::COUNT_W-1:0] o_overlap_count,
    output logic                    o_was_found,
    output logic                    o_table_full,
    output logic        [31:0]      o_query_total
);

    import aptrc_pkg::*;

    t_op                r_op;
    t_entry             r_q;
    logic [CAPACITY-1:0] r_valid;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_chk_idx;
    logic [ADDR_W-1:0]  r_hit_idx;
    logic [ADDR_W-1:0]  r_free_idx;
    logic               r_issue_end;
    logic               r_chk;
    logic               r_found;
    logic               r_have_free;
    logic [COUNT_W-1:0] r_count;
    logic [31:0]        r_qcnt;

    logic               r_out_vld;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_found;
    logic               r_out_full;
    logic [31:0]        r_out_total;

    logic [ENTRY_W-1:0] w_rd_bits;
    t_entry             w_rd;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic               w_ent_vld;
    logic               w_match;
    logic               w_overlap;
    logic               w_keyed;
    logic [31:0]        w_qcnt_nxt;

    aptrc_ram #(
        .P_WIDTH (ENTRY_W),
        .P_DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_q),
        .i_raddr (r_addr),
        .o_rdata (w_rd_bits)
    );

    assign w_rd      = t_entry'(w_rd_bits);
    assign w_ent_vld = r_valid[r_chk_idx];
    assign w_keyed   = (r_op == OP_INSERT) || (r_op == OP_REMOVE);
    assign w_match   = r_chk && w_ent_vld && (w_rd.key == r_q.key);
    assign w_overlap = r_chk && w_ent_vld
                    && ($signed(w_rd.lo_x) <= $signed(r_q.hi_x))
                    && ($signed(w_rd.hi_x) >= $signed(r_q.lo_x))
                    && ($signed(w_rd.lo_y) <= $signed(r_q.hi_y))
                    && ($signed(w_rd.hi_y) >= $signed(r_q.lo_y))
                    && ($signed(w_rd.lo_z) <= $signed(r_q.hi_z))
                    && ($signed(w_rd.hi_z) >= $signed(r_q.lo_z));

    assign w_we       = i_cmd.finish && (r_op == OP_INSERT) && (r_found || r_have_free);
    assign w_waddr    = r_found ? r_hit_idx : r_free_idx;
    assign w_qcnt_nxt = (r_op == OP_QUERY) ? r_qcnt + 32'd1 : r_qcnt;

    assign o_sts.is_clear  = (t_op'(i_op) == OP_CLEAR);
    assign o_sts.scan_done = r_chk && (r_chk_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_qcnt      <= '0;
            r_out_vld   <= 1'b0;
            r_chk       <= 1'b0;
            r_issue_end <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_issue_end <= 1'b0;
                r_chk       <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk <= !r_issue_end;
                if (!r_issue_end && (r_addr == LAST_IDX)) begin
                    r_issue_end <= 1'b1;
                end
            end

            if (i_cmd.finish) begin
                case (r_op)
                    OP_INSERT: begin
                        if (!r_found && r_have_free) begin
                            r_valid[r_free_idx] <= 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        r_valid <= '0;
                    end
                    OP_QUERY: begin
                        r_qcnt <= w_qcnt_nxt;
                    end
                    default: begin
                        r_qcnt <= r_qcnt;
                    end
                endcase
            end

            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_op);
            r_q.key     <= i_object_id;
            r_q.lo_x    <= i_min_x;
            r_q.lo_y    <= i_min_y;
            r_q.lo_z    <= i_min_z;
            r_q.hi_x    <= i_max_x;
            r_q.hi_y    <= i_max_y;
            r_q.hi_z    <= i_max_z;
            r_addr      <= '0;
            r_chk_idx   <= '0;
            r_hit_idx   <= '0;
            r_free_idx  <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_count     <= '0;
        end else if (i_cmd.scan) begin
            if (!r_issue_end) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end
            r_chk_idx <= r_addr;
            if (w_match && w_keyed) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_chk_idx;
            end
            if (r_chk && !w_ent_vld && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_chk_idx;
            end
            if (w_overlap && (r_op == OP_QUERY) && (r_count != COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_count <= r_count;
            r_out_found <= w_keyed && r_found;
            r_out_full  <= (r_op == OP_INSERT) && !r_found && !r_have_free;
            r_out_total <= w_qcnt_nxt;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_overlap_count = r_out_count;
    assign o_was_found     = r_out_found;
    assign o_table_full    = r_out_full;
    assign o_query_total   = r_out_total;

endmodule
`default_nettype wire

// File: hdl/aabb_proxy_table_region_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_proxy_table_region_count
// Table of 3D boxes keyed by object id, with insert, remove, clear and
// box overlap count.
// ----------------------------------------------------------------------------
// One item at a time. Insert, remove and query read every table entry once
// through the single read port of the entry RAM, one entry per cycle; clear
// skips the scan. The input stalls from its transfer until the result is
// placed in the output register; a result waiting there does not hold off the
// next input. Valid bits reset to empty, so no clearing pass is needed after
// reset. Bounds are signed Q16.16 and compared inclusively.
// ----------------------------------------------------------------------------
module aabb_proxy_table_region_count (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [31:0] i_object_id,
    input  wire logic signed [31:0] i_min_x,
    input  wire logic signed [31:0] i_min_y,
    input  wire logic signed [31:0] i_min_z,
    input  wire logic signed [31:0] i_max_x,
    input  wire logic signed [31:0] i_max_y,
    input  wire logic signed [31:0] i_max_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [aptrc_pkg::COUNT_W-1:0] o_overlap_count,
    output logic                    o_was_found,
    output logic                    o_table_full,
    output logic        [31:0]      o_query_total
);

    import aptrc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    aptrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    aptrc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_op            (i_op),
        .i_object_id     (i_object_id),
        .i_min_x         (i_min_x),
        .i_min_y         (i_min_y),
        .i_min_z         (i_min_z),
        .i_max_x         (i_max_x),
        .i_max_y         (i_max_y),
        .i_max_z         (i_max_z),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_overlap_count (o_overlap_count),
        .o_was_found     (o_was_found),
        .o_table_full    (o_table_full),
        .o_query_total   (o_query_total)
    );

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_sts.out_free)
        else $error("result committed while output register occupied");

    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !w_cmd.scan && !w_cmd.finish)
        else $error("input open while an item is in progress");

    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> !o_was_found && (o_overlap_count == '0))
        else $error("table full flag combined with other result");

endmodule
`default_nettype wire
